FILE: rtl/lcm_pkg.sv
package lcm_pkg;

  localparam int unsigned DEF_SET_INDEX_BITS = 14;
  localparam int unsigned DEF_OFFSET_BITS    = 6;
  localparam int unsigned DEF_NUM_WAYS       = 8;
  localparam int unsigned ADDR_W             = 32;

  typedef enum logic [2:0] {
    REQ_READ  = 3'd0,
    REQ_WRITE = 3'd1,
    REQ_INVAL = 3'd2,
    REQ_SNOOP = 3'd3,
    REQ_CLEAR = 3'd4
  } req_code_t;

  typedef enum logic [2:0] {
    KIND_READ,
    KIND_WRITE,
    KIND_INVAL,
    KIND_SNOOP,
    KIND_CLEAR,
    KIND_NOP
  } req_kind_t;

  typedef enum logic [2:0] {
    MSG_NONE  = 3'd0,
    MSG_READ  = 3'd1,
    MSG_WRITE = 3'd2,
    MSG_RFO   = 3'd3,
    MSG_DATA  = 3'd4
  } msg_t;

  typedef enum logic [1:0] {
    COH_I = 2'd0,
    COH_S = 2'd1,
    COH_E = 2'd2,
    COH_M = 2'd3
  } coh_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    req_kind_t         kind;
    logic [ADDR_W-1:0] address;
  } req_item_t;

  typedef struct packed {
    logic sweeping;
  } back_status_t;

endpackage

FILE: rtl/l1_data_cache_mesi_lru.sv
// Flow: a queued request is popped with a read of its directory row from the set
// memory, resolved with the row written back in ST_LOOKUP, and loaded into the output
// register in ST_EMIT, its results in turn unless out_ready stalls. The next request is
// popped only when idle or with the last result of the request before.
// Reset: synchronous; a clearing pass over all 2^SET_INDEX_BITS sets (16384 by default)
// runs after reset and after every clear request, with no transaction accepted.
module l1_data_cache_mesi_lru #(
  parameter int unsigned SET_INDEX_BITS = lcm_pkg::DEF_SET_INDEX_BITS,
  parameter int unsigned OFFSET_BITS    = lcm_pkg::DEF_OFFSET_BITS,
  parameter int unsigned NUM_WAYS       = lcm_pkg::DEF_NUM_WAYS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [31:0] address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        line_found,
  output logic [2:0]  message_kind,
  output logic [31:0] message_line_address,
  output logic        last_result,
  output logic [31:0] reads_total,
  output logic [31:0] writes_total,
  output logic [31:0] hits_total,
  output logic [31:0] misses_total
);
  import lcm_pkg::*;

  // front: classify and queue each transaction
  logic         q_valid;
  req_item_t    q_item;
  logic         q_pop;
  back_status_t status;

  lcm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .address  (address),
    .status   (status),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // back: directory lookup, MESI and LRU update, result sequencing
  lcm_back #(
    .SET_INDEX_BITS (SET_INDEX_BITS),
    .OFFSET_BITS    (OFFSET_BITS),
    .NUM_WAYS       (NUM_WAYS)
  ) u_back (
    .clk                  (clk),
    .rst                  (rst),
    .q_valid              (q_valid),
    .q_item               (q_item),
    .q_pop                (q_pop),
    .status               (status),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .line_found           (line_found),
    .message_kind         (message_kind),
    .message_line_address (message_line_address),
    .last_result          (last_result),
    .reads_total          (reads_total),
    .writes_total         (writes_total),
    .hits_total           (hits_total),
    .misses_total         (misses_total)
  );

  // hold off new transactions during a clearing pass
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    status.sweeping |-> !in_ready)
    else $error("transaction accepted during clearing pass");

  // a result with no message carries a zero line address
  a_none_zero_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && (message_kind == MSG_NONE) |-> (message_line_address == 32'd0))
    else $error("nonzero address without message");

  // the queue never pops when empty
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

FILE: rtl/lcm_front.sv
module lcm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        req_type,
  input  logic [31:0]       address,
  input  lcm_pkg::back_status_t status,
  output logic              q_valid,
  output lcm_pkg::req_item_t q_item,
  input  logic              q_pop
);
  import lcm_pkg::*;

  req_item_t  entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  req_item_t  item_in;
  logic       push;

  // classify the request code
  always_comb begin
    item_in.address = address;
    unique case (req_type)
      REQ_READ:  item_in.kind = KIND_READ;
      REQ_WRITE: item_in.kind = KIND_WRITE;
      REQ_INVAL: item_in.kind = KIND_INVAL;
      REQ_SNOOP: item_in.kind = KIND_SNOOP;
      REQ_CLEAR: item_in.kind = KIND_CLEAR;
      default:   item_in.kind = KIND_NOP;
    endcase
  end

  assign in_ready = (count != 2'd2) && !status.sweeping;
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

FILE: rtl/lcm_back.sv
module lcm_back #(
  parameter int unsigned SET_INDEX_BITS = lcm_pkg::DEF_SET_INDEX_BITS,
  parameter int unsigned OFFSET_BITS    = lcm_pkg::DEF_OFFSET_BITS,
  parameter int unsigned NUM_WAYS       = lcm_pkg::DEF_NUM_WAYS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  lcm_pkg::req_item_t    q_item,
  output logic                  q_pop,
  output lcm_pkg::back_status_t status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  line_found,
  output logic [2:0]            message_kind,
  output logic [31:0]           message_line_address,
  output logic                  last_result,
  output logic [31:0]           reads_total,
  output logic [31:0]           writes_total,
  output logic [31:0]           hits_total,
  output logic [31:0]           misses_total
);
  import lcm_pkg::*;

  localparam int unsigned TAG_W  = ADDR_W - SET_INDEX_BITS - OFFSET_BITS;
  localparam int unsigned IDX_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned SETS   = 1 << SET_INDEX_BITS;
  localparam int unsigned ROW_W  = NUM_WAYS * (TAG_W + 2 + IDX_W);
  localparam int unsigned ST_OFS = NUM_WAYS * TAG_W;
  localparam int unsigned OR_OFS = NUM_WAYS * (TAG_W + 2);

  logic [ROW_W-1:0] mem [SETS];
  logic [ROW_W-1:0] rd_row;
  logic             rd_en, wr_en;
  logic [SET_INDEX_BITS-1:0] rd_set, wr_set;
  logic [ROW_W-1:0] wr_row, reset_row, new_row;

  back_state_t state, state_next;
  logic [SET_INDEX_BITS-1:0] sweep_idx, sweep_idx_next;
  req_item_t cur, cur_next;
  logic      clear_pend, clear_pend_next;
  logic [1:0] emit_idx, emit_idx_next;
  logic [1:0] res_cnt, res_cnt_next;
  logic       res_found, res_found_next;
  msg_t       res_kind [3];
  msg_t       res_kind_next [3];
  logic [31:0] res_addr [3];
  logic [31:0] res_addr_next [3];
  logic [31:0] rd_cnt, wr_cnt, hit_cnt, miss_cnt;
  logic [31:0] rd_cnt_next, wr_cnt_next, hit_cnt_next, miss_cnt_next;
  logic        load_out, load_last;

  // set view of the registered row
  logic [TAG_W-1:0] tag_of [NUM_WAYS];
  coh_t             st_of  [NUM_WAYS];
  logic [IDX_W-1:0] ord    [NUM_WAYS];
  coh_t             st_new [NUM_WAYS];
  logic [IDX_W-1:0] ord_new[NUM_WAYS];
  logic [TAG_W-1:0] tag_new[NUM_WAYS];

  logic [TAG_W-1:0]          ctag;
  logic [SET_INDEX_BITS-1:0] cset;
  logic [31:0]               laddr, vaddr;
  logic                      found, vfound, pfound;
  logic [IDX_W-1:0]          hway, vway, mway;
  logic [IDX_W-1:0]          pos;

  assign ctag  = cur.address[ADDR_W-1 -: TAG_W];
  assign cset  = cur.address[OFFSET_BITS +: SET_INDEX_BITS];
  assign laddr = {ctag, cset, {OFFSET_BITS{1'b0}}};

  always_comb begin
    reset_row = '0;
    for (int r = 0; r < NUM_WAYS; r++) begin
      reset_row[OR_OFS + r*IDX_W +: IDX_W] = IDX_W'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_set] <= wr_row;
    if (rd_en) rd_row <= mem[rd_set];
  end

  // lookup datapath
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      tag_of[w] = rd_row[w*TAG_W +: TAG_W];
      st_of[w]  = coh_t'(rd_row[ST_OFS + w*2 +: 2]);
      ord[w]    = rd_row[OR_OFS + w*IDX_W +: IDX_W];
    end
    found = 1'b0;
    hway  = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!found && st_of[w] != COH_I && tag_of[w] == ctag) begin
        found = 1'b1;
        hway  = IDX_W'(w);
      end
    end
    vfound = 1'b0;
    vway   = ord[0];
    for (int r = 0; r < NUM_WAYS; r++) begin
      if (!vfound && st_of[ord[r]] == COH_I) begin
        vfound = 1'b1;
        vway   = ord[r];
      end
    end
    vaddr = {tag_of[vway], cset, {OFFSET_BITS{1'b0}}};
    mway  = found ? hway : vway;
    pfound = 1'b0;
    pos    = '0;
    for (int r = 0; r < NUM_WAYS; r++) begin
      if (!pfound && ord[r] == mway) begin
        pfound = 1'b1;
        pos    = IDX_W'(r);
      end
    end
  end

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      tag_new[w] = tag_of[w];
      st_new[w]  = st_of[w];
      ord_new[w] = ord[w];
    end
    res_found_next = found;
    res_cnt_next   = 2'd1;
    for (int k = 0; k < 3; k++) begin
      res_kind_next[k] = MSG_NONE;
      res_addr_next[k] = '0;
    end
    rd_cnt_next   = rd_cnt;
    wr_cnt_next   = wr_cnt;
    hit_cnt_next  = hit_cnt;
    miss_cnt_next = miss_cnt;
    unique case (cur.kind)
      KIND_READ, KIND_WRITE: begin
        if (cur.kind == KIND_READ) rd_cnt_next = rd_cnt + 32'd1;
        else wr_cnt_next = wr_cnt + 32'd1;
        // move the touched way to the MRU end
        for (int r = 0; r < NUM_WAYS; r++) begin
          if (IDX_W'(r) >= pos) begin
            ord_new[r] = (r < NUM_WAYS - 1) ? ord[(r + 1) % NUM_WAYS] : mway;
          end
        end
        if (found) begin
          hit_cnt_next = hit_cnt + 32'd1;
          if (cur.kind == KIND_WRITE && st_of[hway] != COH_M) begin
            st_new[hway]     = COH_M;
            res_kind_next[0] = MSG_WRITE;
            res_addr_next[0] = laddr;
          end
        end else begin
          miss_cnt_next = miss_cnt + 32'd1;
          tag_new[vway] = ctag;
          st_new[vway]  = (cur.kind == KIND_READ) ? COH_E : COH_M;
          if (st_of[vway] == COH_M) begin
            res_kind_next[0] = MSG_WRITE;
            res_addr_next[0] = vaddr;
            if (cur.kind == KIND_READ) begin
              res_kind_next[1] = MSG_READ;
              res_addr_next[1] = laddr;
              res_cnt_next     = 2'd2;
            end else begin
              res_kind_next[1] = MSG_RFO;
              res_addr_next[1] = laddr;
              res_kind_next[2] = MSG_WRITE;
              res_addr_next[2] = laddr;
              res_cnt_next     = 2'd3;
            end
          end else if (cur.kind == KIND_READ) begin
            res_kind_next[0] = MSG_READ;
            res_addr_next[0] = laddr;
          end else begin
            res_kind_next[0] = MSG_RFO;
            res_addr_next[0] = laddr;
            res_kind_next[1] = MSG_WRITE;
            res_addr_next[1] = laddr;
            res_cnt_next     = 2'd2;
          end
        end
      end
      KIND_INVAL: begin
        if (found) begin
          if (st_of[hway] == COH_M) begin
            res_kind_next[0] = MSG_WRITE;
            res_addr_next[0] = laddr;
          end
          st_new[hway] = COH_I;
        end
      end
      KIND_SNOOP: begin
        if (found && st_of[hway] == COH_M) begin
          st_new[hway]     = COH_S;
          res_kind_next[0] = MSG_DATA;
          res_addr_next[0] = laddr;
        end
      end
      KIND_CLEAR: begin
        res_found_next = 1'b0;
        rd_cnt_next    = '0;
        wr_cnt_next    = '0;
        hit_cnt_next   = '0;
        miss_cnt_next  = '0;
      end
      default: begin
        res_found_next = 1'b0;
      end
    endcase
    for (int w = 0; w < NUM_WAYS; w++) begin
      new_row[w*TAG_W +: TAG_W]          = tag_new[w];
      new_row[ST_OFS + w*2 +: 2]         = st_new[w];
      new_row[OR_OFS + w*IDX_W +: IDX_W] = ord_new[w];
    end
  end

  // sequencer
  always_comb begin
    state_next      = state;
    sweep_idx_next  = sweep_idx;
    cur_next        = cur;
    clear_pend_next = clear_pend;
    emit_idx_next   = emit_idx;
    q_pop           = 1'b0;
    rd_en           = 1'b0;
    rd_set          = q_item.address[OFFSET_BITS +: SET_INDEX_BITS];
    wr_en           = 1'b0;
    wr_set          = cset;
    wr_row          = new_row;
    load_out        = 1'b0;
    load_last       = (emit_idx == res_cnt - 2'd1);
    unique case (state)
      ST_SWEEP: begin
        wr_en          = 1'b1;
        wr_set         = sweep_idx;
        wr_row         = reset_row;
        sweep_idx_next = sweep_idx + SET_INDEX_BITS'(1);
        if (&sweep_idx) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          rd_en      = 1'b1;
          cur_next   = q_item;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        wr_en           = (cur.kind != KIND_CLEAR);
        clear_pend_next = (cur.kind == KIND_CLEAR);
        emit_idx_next   = 2'd0;
        state_next      = ST_EMIT;
      end
      ST_EMIT: begin
        load_out = !out_valid || out_ready;
        if (load_out) begin
          emit_idx_next = emit_idx + 2'd1;
          if (load_last) begin
            if (clear_pend) begin
              sweep_idx_next = '0;
              state_next     = ST_SWEEP;
            end else if (q_valid) begin
              q_pop      = 1'b1;
              rd_en      = 1'b1;
              cur_next   = q_item;
              state_next = ST_LOOKUP;
            end else begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign status.sweeping = (state == ST_SWEEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_idx  <= '0;
      clear_pend <= 1'b0;
      emit_idx   <= '0;
      rd_cnt     <= '0;
      wr_cnt     <= '0;
      hit_cnt    <= '0;
      miss_cnt   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      sweep_idx  <= sweep_idx_next;
      clear_pend <= clear_pend_next;
      emit_idx   <= emit_idx_next;
      if (state == ST_LOOKUP) begin
        rd_cnt   <= rd_cnt_next;
        wr_cnt   <= wr_cnt_next;
        hit_cnt  <= hit_cnt_next;
        miss_cnt <= miss_cnt_next;
      end
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (state == ST_LOOKUP) begin
      res_cnt   <= res_cnt_next;
      res_found <= res_found_next;
      for (int k = 0; k < 3; k++) begin
        res_kind[k] <= res_kind_next[k];
        res_addr[k] <= res_addr_next[k];
      end
    end
    if (load_out) begin
      line_found           <= res_found;
      message_kind         <= res_kind[emit_idx];
      message_line_address <= res_addr[emit_idx];
      last_result          <= load_last;
      reads_total          <= rd_cnt;
      writes_total         <= wr_cnt;
      hits_total           <= hit_cnt;
      misses_total         <= miss_cnt;
    end
  end

endmodule
